// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion shorthands used by the checker module
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, skipped while reset is high
`define ASSERT_CLK_RST(label, clk_sig, rst_sig, prop, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) prop) \
    else $error(msg);

// property checked on every rising edge, reset included
`define ASSERT_CLK(label, clk_sig, prop, msg) \
  label: assert property (@(posedge clk_sig) prop) else $error(msg);

`endif

// ===== sv/nps_pkg.sv =====
// ----------------------------------------------------------------------------
// nps_pkg
// shared types and constants of the non-overlapping pattern search unit
// ----------------------------------------------------------------------------
package nps_pkg;

  // default parameter values
  localparam int MAX_PATTERN_DEF = 8;
  localparam int INDEX_WIDTH_DEF = 16;

  // fixed field widths
  localparam int BYTE_W      = 8;
  localparam int PATTERN_W   = 64;
  localparam int LENGTH_W    = 4;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_INDEX_W = 2;
  localparam int MATCH_W     = 16;
  localparam int COUNT_W     = 3;

  localparam logic [COUNT_W-1:0]  COUNT_MAX    = '1;
  localparam logic [LENGTH_W-1:0] LENGTH_RESET = 4'd1;

  // configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PATTERN_BYTES  = 2'd0,
    REG_PATTERN_LENGTH = 2'd1,
    REG_INDEX_AFTER    = 2'd2
  } cfg_reg_t;

  // outcome of one byte compare
  typedef struct packed {
    logic               hit;
    logic [MATCH_W-1:0] index;
  } nps_result_t;

endpackage

// ===== sv/nps_match.sv =====
// ----------------------------------------------------------------------------
// nps_match
// window compare against the pattern and match index computation
// ----------------------------------------------------------------------------
module nps_match import nps_pkg::*; #(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF,
  parameter int INDEX_WIDTH = INDEX_WIDTH_DEF,
  localparam int HIST_W     = (MAX_PATTERN > 1) ? (MAX_PATTERN - 1) * BYTE_W : BYTE_W,
  localparam int WIN_W      = HIST_W + BYTE_W
) (
  input  logic [PATTERN_W-1:0]   pattern_bytes,
  input  logic [LENGTH_W-1:0]    pattern_length,
  input  logic                   index_after_match,
  input  logic [WIN_W-1:0]       window,          // newest byte in the low byte
  input  logic [INDEX_WIDTH-1:0] byte_position,
  input  logic [COUNT_W-1:0]     clean_count,
  output nps_result_t            result
);

  localparam logic [INDEX_WIDTH-1:0] POS_MAX = '1;

  logic [LENGTH_W-1:0]    len;
  logic [LENGTH_W-1:0]    len_m1;
  logic [LENGTH_W-1:0]    off;
  logic                   bytes_ok;
  logic                   enough;
  logic [INDEX_WIDTH-1:0] idx;
  logic [31:0]            idx_wide;

  // clamp the length into 1..MAX_PATTERN
  always_comb begin
    if (pattern_length == '0) begin
      len = LENGTH_W'(1);
    end else if (pattern_length > LENGTH_W'(MAX_PATTERN)) begin
      len = LENGTH_W'(MAX_PATTERN);
    end else begin
      len = pattern_length;
    end
    len_m1 = len - LENGTH_W'(1);
  end

  // byte k of the pattern against the byte len-1-k places back
  always_comb begin
    bytes_ok = 1'b1;
    off      = '0;
    for (int k = 0; k < MAX_PATTERN; k++) begin
      if (LENGTH_W'(k) < len) begin
        off = len_m1 - LENGTH_W'(k);
        if (pattern_bytes[BYTE_W*k +: BYTE_W] != window[BYTE_W*off +: BYTE_W]) begin
          bytes_ok = 1'b0;
        end
      end
    end
  end

  // all matched bytes must have arrived since start or last match
  assign enough = ({1'b0, clean_count} + (COUNT_W + 1)'(1)) >= (COUNT_W + 1)'(len);

  // reported index per mode
  always_comb begin
    if (index_after_match) begin
      idx = (byte_position == POS_MAX) ? POS_MAX : byte_position + INDEX_WIDTH'(1);
    end else if (byte_position >= INDEX_WIDTH'(len_m1)) begin
      idx = byte_position - INDEX_WIDTH'(len_m1);
    end else begin
      idx = '0;
    end
    idx_wide = 32'(idx);
  end

  assign result.hit   = bytes_ok && enough;
  assign result.index = idx_wide[MATCH_W-1:0];

endmodule

// ===== sv/nonoverlapping_pattern_search_unit.sv =====
// ----------------------------------------------------------------------------
// nonoverlapping_pattern_search_unit
// streaming exact search for non-overlapping occurrences of a short pattern
// ----------------------------------------------------------------------------
// channel   direction  payload
// s_*       in         tdata: data_byte[7:0]; tuser: string_start
// m_*       out        tdata: match_index[15:0]
// cfg_*     in         cfg_index selects register, cfg_data holds the value
//
// one byte is taken per cycle while no stalled result blocks the input; a byte
// is first held in the input register, then its compare result is loaded
// into the result register, and a match shows on m_*
// rst clears history, position, count, configuration registers and both valid flags
// s_tready drops only while a stalled result waits and a byte is held
// cfg_ready is always high; write only while the unit is idle
// ----------------------------------------------------------------------------
module nonoverlapping_pattern_search_unit import nps_pkg::*; #(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF,
  parameter int INDEX_WIDTH = INDEX_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [BYTE_W-1:0]      s_tdata,   // [7:0] data_byte
  input  logic                   s_tuser,   // [0] string_start
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [MATCH_W-1:0]     m_tdata,   // [15:0] match_index
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int HIST_W = (MAX_PATTERN > 1) ? (MAX_PATTERN - 1) * BYTE_W : BYTE_W;
  localparam int WIN_W  = HIST_W + BYTE_W;
  localparam logic [INDEX_WIDTH-1:0] POS_MAX = '1;

  // configuration registers
  logic [PATTERN_W-1:0] pattern_bytes;
  logic [LENGTH_W-1:0]  pattern_length;
  logic                 index_after_match;

  // input register
  logic              in_valid;
  logic [BYTE_W-1:0] in_byte;
  logic              in_start;

  // search state
  logic [HIST_W-1:0]      recent_bytes;
  logic [INDEX_WIDTH-1:0] byte_position;
  logic [COUNT_W-1:0]     clean_count;

  logic [HIST_W-1:0]      hist_eff;
  logic [INDEX_WIDTH-1:0] pos_eff;
  logic [COUNT_W-1:0]     count_eff;
  logic [WIN_W-1:0]       window;
  logic [COUNT_W-1:0]     clean_count_next;
  nps_result_t            result;
  logic                   fire;

  assign cfg_ready = 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes     <= '0;
      pattern_length    <= LENGTH_RESET;
      index_after_match <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_PATTERN_BYTES:  pattern_bytes     <= cfg_data;
        REG_PATTERN_LENGTH: pattern_length    <= cfg_data[LENGTH_W-1:0];
        REG_INDEX_AFTER:    index_after_match <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // compare stage runs when the result register is free or drains
  assign fire     = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || fire;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte  <= s_tdata;
      in_start <= s_tuser;
    end
  end

  // a new text clears history, position and count before the byte
  always_comb begin
    hist_eff  = in_start ? '0 : recent_bytes;
    pos_eff   = in_start ? '0 : byte_position;
    count_eff = in_start ? '0 : clean_count;
    window    = {hist_eff, in_byte};
  end

  nps_match #(
    .MAX_PATTERN(MAX_PATTERN),
    .INDEX_WIDTH(INDEX_WIDTH)
  ) u_match (
    .pattern_bytes    (pattern_bytes),
    .pattern_length   (pattern_length),
    .index_after_match(index_after_match),
    .window           (window),
    .byte_position    (pos_eff),
    .clean_count      (count_eff),
    .result           (result)
  );

  // count restarts after a match and saturates otherwise
  always_comb begin
    if (result.hit) begin
      clean_count_next = '0;
    end else if (count_eff == COUNT_MAX) begin
      clean_count_next = COUNT_MAX;
    end else begin
      clean_count_next = count_eff + COUNT_W'(1);
    end
  end

  // state update
  always_ff @(posedge clk) begin
    if (rst) begin
      recent_bytes  <= '0;
      byte_position <= '0;
      clean_count   <= '0;
    end else if (fire) begin
      recent_bytes  <= window[HIST_W-1:0];
      byte_position <= (pos_eff == POS_MAX) ? POS_MAX : pos_eff + INDEX_WIDTH'(1);
      clean_count   <= clean_count_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= result.hit;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && result.hit) begin
      m_tdata <= result.index;
    end
  end

endmodule

// ===== sv/nps_checker.sv =====
// ----------------------------------------------------------------------------
// nps_checker
// port-level checks of the pattern search unit, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nps_checker import nps_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               s_tvalid,
  input logic               s_tready,
  input logic               m_tvalid,
  input logic               m_tready,
  input logic [MATCH_W-1:0] m_tdata
);

  // a stalled result holds its value
  `ASSERT_CLK_RST(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed while stalled")

  // reset leaves no result pending
  `ASSERT_CLK(a_reset_clear, clk, rst |=> !m_tvalid, "result valid after reset")

  // input backpressure only while a result is stalled
  `ASSERT_CLK_RST(a_ready_low, clk, rst, !s_tready |-> m_tvalid && !m_tready, "input stalled without output stall")

  // with no result pending the input never stalls
  `ASSERT_CLK_RST(a_no_stall, clk, rst, !m_tvalid |-> s_tready, "input stalled with empty output")

endmodule

bind nonoverlapping_pattern_search_unit nps_checker u_nps_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata)
);
